### hdl/lms_pkg.sv
// Shared types and constants for the LED mode sequencer.
package lms_pkg;

	localparam int unsigned CfgWidth     = 10;
	localparam int unsigned PotWidth     = 10;
	localparam int unsigned ElapsedWidth = 11;
	localparam int unsigned PhaseWidth   = 13;
	localparam int unsigned LedCount     = 3;

	typedef logic [CfgWidth-1:0]     cfg_word_t;
	typedef logic [ElapsedWidth-1:0] elapsed_t;
	typedef logic [PhaseWidth-1:0]   phase_t;
	typedef logic [LedCount-1:0]     led_vec_t;
	typedef logic [1:0]              cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_ON     = 2'd1,
		MODE_BLINK  = 2'd2,
		MODE_BOUNCE = 2'd3
	} mode_t;

	localparam cfg_idx_t CFG_DEBOUNCE = 2'd0;
	localparam cfg_idx_t CFG_STEP     = 2'd1;

	localparam cfg_word_t DEBOUNCE_RESET = 10'd50;
	localparam cfg_word_t STEP_RESET     = 10'd100;

	localparam led_vec_t LED_NONE = 3'b000;
	localparam led_vec_t LED_ALL  = 3'b111;
	localparam led_vec_t LED_A    = 3'b001;
	localparam led_vec_t LED_B    = 3'b010;
	localparam led_vec_t LED_C    = 3'b100;

	// Mode before and after the current beat, handed from debounce to LED logic.
	typedef struct packed {
		mode_t mode_old;
		mode_t mode_new;
	} mode_info_t;

endpackage

### hdl/lms_debounce.sv
// Button debouncer and mode counter of the LED mode sequencer.
module lms_debounce import lms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic       button_sample,
	input  cfg_word_t  debounce_ms,
	output mode_info_t mode_info
);

	logic     last_sample_q;
	logic     stable_level_q;
	elapsed_t elapsed_q;
	mode_t    mode_q;

	elapsed_t elapsed_d;
	logic     take_level;
	mode_t    mode_d;

	always_comb begin
		if (button_sample != last_sample_q) begin
			elapsed_d = '0;
		end else if (elapsed_q == '1) begin
			elapsed_d = elapsed_q;
		end else begin
			elapsed_d = elapsed_q + ElapsedWidth'(1);
		end
		take_level = (elapsed_d > ElapsedWidth'(debounce_ms)) &&
			(button_sample != stable_level_q);
		mode_d = mode_q;
		if (take_level && button_sample) begin
			mode_d = mode_t'(mode_q + 2'd1);
		end
	end

	assign mode_info.mode_old = mode_q;
	assign mode_info.mode_new = mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q  <= 1'b1;
			stable_level_q <= 1'b0;
			elapsed_q      <= '0;
			mode_q         <= MODE_OFF;
		end else if (step_en) begin
			last_sample_q <= button_sample;
			elapsed_q     <= elapsed_d;
			mode_q        <= mode_d;
			if (take_level) begin
				stable_level_q <= button_sample;
			end
		end
	end

endmodule

### hdl/led_mode_sequencer.sv
// Top level of the LED mode sequencer: config registers, LED pattern logic, result register.
//
// Channel  Signals                                   Direction  Beat
// in       in_valid/in_ready, button_sample, pot_level  sink     one millisecond tick
// out      out_valid/out_ready, led_a..c, mode_now   source     LED state after that tick
// cfg      cfg_we, cfg_index, cfg_data               sink       one register write
//
// Every accepted input beat updates the debouncer, mode and LED state in the same
// cycle and loads one result into the output register, so one beat per clock is
// sustained while the consumer keeps up; each result is held in that output register.
// The input is ready whenever the output register is empty or is being drained,
// so a stalled consumer holds back the input only while a result waits.
// Reset clears output valid and returns all else to defaults but the result payload.
module led_mode_sequencer import lms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                button_sample,
	input  logic [PotWidth-1:0] pot_level,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                led_a,
	output logic                led_b,
	output logic                led_c,
	output logic [1:0]          mode_now,
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_index,
	input  cfg_word_t           cfg_data
);

	cfg_word_t  debounce_ms_q;
	cfg_word_t  step_ms_q;
	phase_t     phase_q;
	led_vec_t   led_q;
	logic       out_valid_q;
	led_vec_t   res_led_q;
	mode_t      res_mode_q;

	logic       accept;
	mode_info_t mode_info;
	phase_t     phase_inc;
	phase_t     phase_d;
	led_vec_t   led_d;
	phase_t     step_x1;
	phase_t     step_x2;
	phase_t     step_x3;
	phase_t     step_x4;
	phase_t     step_x5;
	phase_t     step_x6;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= DEBOUNCE_RESET;
			step_ms_q     <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_ms_q <= cfg_data;
				CFG_STEP:     step_ms_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	lms_debounce u_debounce (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (accept),
		.button_sample(button_sample),
		.debounce_ms  (debounce_ms_q),
		.mode_info    (mode_info)
	);

	// Slot boundaries of the bounce sequence; multiples built from shifts and adds.
	assign step_x1 = PhaseWidth'(step_ms_q);
	assign step_x2 = step_x1 << 1;
	assign step_x3 = step_x2 + step_x1;
	assign step_x4 = step_x1 << 2;
	assign step_x5 = step_x4 + step_x1;
	assign step_x6 = step_x3 << 1;

	assign phase_inc = (phase_q == '1) ? phase_q : phase_q + PhaseWidth'(1);

	always_comb begin
		phase_d = phase_inc;
		led_d   = led_q;
		case (mode_info.mode_new)
			MODE_OFF: begin
				led_d = LED_NONE;
			end
			MODE_ON: begin
				led_d = LED_ALL;
			end
			MODE_BLINK: begin
				// The blink timer restarts on entry; exceeding the pot value toggles all LEDs.
				if (mode_info.mode_old != MODE_BLINK) begin
					phase_d = '0;
				end
				if (phase_d > PhaseWidth'(pot_level)) begin
					led_d   = ~led_q;
					phase_d = '0;
				end
			end
			default: begin
				// Bounce sequence: later slot tests override earlier ones.
				if (mode_info.mode_old != MODE_BOUNCE) begin
					phase_d = '0;
					led_d   = LED_NONE;
				end
				if (phase_d > step_x1) begin
					led_d = led_d | LED_A;
				end
				if (phase_d > step_x2) begin
					led_d = (led_d & ~LED_A) | LED_B;
				end
				if (phase_d > step_x3) begin
					led_d = (led_d & ~LED_B) | LED_C;
				end
				if (phase_d > step_x4) begin
					led_d = (led_d & ~LED_C) | LED_B;
				end
				if (phase_d > step_x5) begin
					led_d = (led_d & ~LED_B) | LED_A;
				end
				if (phase_d > step_x6) begin
					led_d   = led_d & ~LED_A;
					phase_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			led_q       <= LED_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				led_q       <= led_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded with each accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_led_q  <= led_d;
			res_mode_q <= mode_info.mode_new;
		end
	end

	assign out_valid = out_valid_q;
	assign led_a     = res_led_q[0];
	assign led_b     = res_led_q[1];
	assign led_c     = res_led_q[2];
	assign mode_now  = res_mode_q;

endmodule

### sim/lms_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the LED mode sequencer: tick predictor, expected-result queue and compare.
module lms_checker import lms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                button_sample,
	input  logic [PotWidth-1:0] pot_level,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                led_a,
	input  logic                led_b,
	input  logic                led_c,
	input  logic [1:0]          mode_now,
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_index,
	input  cfg_word_t           cfg_data,
	output int unsigned         backlog,
	output int unsigned         fail_total
);

	localparam int unsigned ReportLimit = 10;

	typedef struct packed {
		led_vec_t leds;
		mode_t    mode;
	} panel_t;

	// Shadow copy of the block's state and registers.
	logic      last_level;
	logic      settled_level;
	elapsed_t  hold_ticks;
	mode_t     cur_mode;
	phase_t    phase_ticks;
	led_vec_t  led_state;
	cfg_word_t debounce_len;
	cfg_word_t slot_len;

	panel_t expected_panels[$];

	// Advances the shadow state by one tick and returns the LED panel it shows.
	function automatic panel_t advance_panel(logic btn, logic [PotWidth-1:0] pot);
		mode_t      prior;
		logic [1:0] next_mode;
		int         p;
		int         s;
		prior = cur_mode;

		// Debounce first, so the mode logic below already sees a new press.
		if (btn != last_level)
			hold_ticks = '0;
		else if (hold_ticks != '1)
			hold_ticks++;
		if (hold_ticks > debounce_len && btn != settled_level) begin
			settled_level = btn;
			if (btn) begin
				next_mode = cur_mode + 2'd1;
				cur_mode  = mode_t'(next_mode);
			end
		end
		last_level = btn;

		case (cur_mode)
			MODE_OFF: begin
				led_state = LED_NONE;
				if (phase_ticks != '1)
					phase_ticks++;
			end
			MODE_ON: begin
				led_state = LED_ALL;
				if (phase_ticks != '1)
					phase_ticks++;
			end
			MODE_BLINK: begin
				if (prior != MODE_BLINK)
					phase_ticks = '0;
				else if (phase_ticks != '1)
					phase_ticks++;
				if (phase_ticks > pot) begin
					led_state   = ~led_state;
					phase_ticks = '0;
				end
			end
			default: begin
				if (prior != MODE_BOUNCE) begin
					phase_ticks = '0;
					led_state   = LED_NONE;
				end else if (phase_ticks != '1) begin
					phase_ticks++;
				end
				// All six slot tests run in order; the last one that passes wins.
				p = int'(phase_ticks);
				s = int'(slot_len);
				if (p > s)
					led_state |= LED_A;
				if (p > 2 * s)
					led_state = (led_state & ~LED_A) | LED_B;
				if (p > 3 * s)
					led_state = (led_state & ~LED_B) | LED_C;
				if (p > 4 * s)
					led_state = (led_state & ~LED_C) | LED_B;
				if (p > 5 * s)
					led_state = (led_state & ~LED_B) | LED_A;
				if (p > 6 * s) begin
					led_state &= ~LED_A;
					phase_ticks = '0;
				end
			end
		endcase
		return '{leds: led_state, mode: cur_mode};
	endfunction

	task automatic flag_failure(input string what);
		if (fail_total < ReportLimit)
			$display("[%0t] mismatch: %s", $realtime, what);
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		panel_t want;
		if (!arst_n) begin
			last_level    = 1'b1;
			settled_level = 1'b0;
			hold_ticks    = '0;
			cur_mode      = MODE_OFF;
			phase_ticks   = '0;
			led_state     = LED_NONE;
			debounce_len  = DEBOUNCE_RESET;
			slot_len      = STEP_RESET;
			expected_panels.delete();
			backlog       = 0;
			fail_total    = 0;
		end else begin
			// A result leaving now always belongs to a tick taken at an earlier edge.
			if (out_valid && out_ready) begin
				if (expected_panels.size() == 0) begin
					flag_failure($sformatf("unexpected beat: leds %b%b%b mode %0d",
						led_c, led_b, led_a, mode_now));
				end else begin
					want = expected_panels.pop_front();
					if (led_a !== want.leds[0] || led_b !== want.leds[1] ||
					    led_c !== want.leds[2] || mode_now !== want.mode)
						flag_failure($sformatf(
							"expected leds %b mode %0d, got leds %b%b%b mode %0d",
							want.leds, want.mode, led_c, led_b, led_a, mode_now));
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_DEBOUNCE)
					debounce_len = cfg_data;
				else if (cfg_index == CFG_STEP)
					slot_len = cfg_data;
			end
			if (in_valid && in_ready)
				expected_panels.push_back(advance_panel(button_sample, pot_level));
			backlog = expected_panels.size();
		end
	end

endmodule

### sim/tb_led_mode_sequencer.sv
`timescale 1ns / 100ps
// Top of the LED mode sequencer testbench: clock, reset, tick stimulus, stalls and verdict.
module tb_led_mode_sequencer;
	import lms_pkg::*;

	// Generous cycle budget for the whole run.
	localparam int unsigned RunLimit    = 400000;
	// Index that decodes to no register; writes to it must leave both alone.
	localparam cfg_idx_t    CFG_UNUSED  = 2'd2;
	// Idle cycles after the final drain; the block has a single output register.
	localparam int unsigned DrainCycles = 8;
	localparam int unsigned PhaseCount  = 6;

	// Random phases: each one runs with its own register setting and tick budget.
	// The debounce settings cover both ends of its range; the step settings run from 1 to 1023.
	localparam int unsigned DebouncePlan [PhaseCount] = '{50, 0, 1023, 4, 9, 2};
	localparam int unsigned StepPlan     [PhaseCount] = '{100, 1, 2, 7, 3, 1023};
	localparam int unsigned TickPlan     [PhaseCount] = '{300, 300, 250, 350, 350, 300};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic                button_sample = 1'b0;
	logic [PotWidth-1:0] pot_level     = '0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic                led_a;
	logic                led_b;
	logic                led_c;
	logic [1:0]          mode_now;
	logic                cfg_we        = 1'b0;
	cfg_idx_t            cfg_index     = CFG_DEBOUNCE;
	cfg_word_t           cfg_data      = '0;

	int unsigned backlog;
	int unsigned fail_total;
	int unsigned cycle_count = 0;

	// Sender idling: ticks go out in bursts separated by short gaps when enabled.
	logic        idle_on    = 1'b1;
	int unsigned burst_left = 0;
	// The button level that the well-formed presses and releases currently hold.
	logic        level_now  = 1'b0;

	// Receiver stall pattern and the counter that steps through it and times its replacement.
	logic [15:0] ready_mask = 16'hffff;
	int unsigned ready_tick = 0;

	led_mode_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_sample(button_sample),
		.pot_level    (pot_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_a        (led_a),
		.led_b        (led_b),
		.led_c        (led_c),
		.mode_now     (mode_now),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lms_checker u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_sample(button_sample),
		.pot_level    (pot_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_a        (led_a),
		.led_b        (led_b),
		.led_c        (led_c),
		.mode_now     (mode_now),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.backlog      (backlog),
		.fail_total   (fail_total)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RunLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver picks a new pattern now and then: no stalls at all, a random
	// mix, or a single ready slot in sixteen, which makes long stalls. Ready
	// changes on the falling edge like every other input.
	always @(negedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_tick % 64 == 0) begin
			if ($urandom_range(0, 3) == 0)
				ready_mask <= 16'hffff;
			else if ($urandom_range(0, 2) == 0)
				ready_mask <= 16'(1 << $urandom_range(0, 15));
			else
				ready_mask <= 16'($urandom()) | 16'h0001;
		end
		out_ready <= ready_mask[ready_tick % 16];
	end

	// Sends one tick. It is entered on a falling edge and returns on the falling
	// edge after the beat was taken, with valid still high so that the next tick
	// can follow without a bubble. A gap drops valid first.
	task automatic send_tick(input logic lvl, input logic [PotWidth-1:0] pot);
		int unsigned gap;
		if (idle_on && burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid      <= 1'b1;
		button_sample <= lvl;
		pot_level     <= pot;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_run(input logic lvl, input logic [PotWidth-1:0] pot,
			input int unsigned count);
		repeat (count) send_tick(lvl, pot);
	endtask

	// Holds the sender off until every predicted result has come out, then lets the
	// output register settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (backlog != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Register writes only happen with the block idle.
	task automatic write_reg(input cfg_idx_t idx, input cfg_word_t value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Random ticks. Most runs are clean presses or releases held just past the
	// debounce time, so the mode keeps cycling; some are held much longer so the
	// blink and bounce patterns play out. The rest are glitches too short to be
	// accepted. The pot value is mostly small so blinking is frequent, but it also
	// covers the full range, and some runs change it on every tick.
	task automatic run_phase(input int unsigned ticks, input int unsigned debounce,
			input logic drain_midway);
		int unsigned sent;
		int unsigned run_len;
		logic        lvl;
		logic        per_tick_pot;
		logic [PotWidth-1:0] pot;
		sent = 0;
		while (sent < ticks) begin
			if ($urandom_range(0, 4) == 0) begin
				lvl     = 1'($urandom_range(0, 1));
				run_len = $urandom_range(1, debounce + 1);
			end else begin
				level_now = ~level_now;
				lvl       = level_now;
				run_len   = debounce + 2 + $urandom_range(0, 4);
				if ($urandom_range(0, 5) == 0)
					run_len += $urandom_range(0, 700);
			end
			if ($urandom_range(0, 3) == 0)
				pot = PotWidth'($urandom_range(0, 1023));
			else
				pot = PotWidth'($urandom_range(0, 12));
			per_tick_pot = ($urandom_range(0, 7) == 0);
			for (int unsigned k = 0; k < run_len && sent < ticks; k++) begin
				if (per_tick_pot)
					pot = PotWidth'($urandom_range(0, 1023));
				send_tick(lvl, pot);
				sent++;
				// Let the pipeline run completely dry once in the middle of a phase.
				if (drain_midway && sent == ticks / 2)
					wait_drained();
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. With a debounce of 1, a new level is taken on the third
		// tick that it holds, and a step of 1 runs the whole bounce sequence in a
		// handful of ticks.
		write_reg(CFG_DEBOUNCE, 10'd1);
		write_reg(CFG_STEP, 10'd1);
		// A write to an index with no register behind it must change nothing; a
		// debounce of 0 would let the short press below through.
		write_reg(CFG_UNUSED, 10'd0);

		send_run(1'b0, 10'd0, 1);
		// Held for two ticks only: one short of the debounce time, so rejected.
		send_run(1'b1, 10'd0, 2);
		send_run(1'b0, 10'd1023, 1);
		send_run(1'b1, 10'd0, 3);     // accepted press: all LEDs on
		send_run(1'b0, 10'd0, 3);     // release becomes the stable level
		send_run(1'b1, 10'd0, 3);     // blink on the third tick; entry restarts the timer
		send_run(1'b1, 10'd1023, 2);  // longest half-period holds the LEDs
		send_run(1'b0, 10'd1, 3);
		send_run(1'b1, 10'd1, 3);     // bounce entry clears the LEDs
		send_run(1'b1, 10'd0, 7);     // a, b, c, b, a, then off and restart

		// Random phases. Phase 1 runs without sender gaps so that back-to-back beats
		// meet the receiver stalls directly.
		for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
			write_reg(CFG_DEBOUNCE, cfg_word_t'(DebouncePlan[ph]));
			write_reg(CFG_STEP, cfg_word_t'(StepPlan[ph]));
			idle_on    = (ph != 1);
			burst_left = 0;
			run_phase(TickPlan[ph], DebouncePlan[ph], ph == 3);
		end

		wait_drained();
		repeat (DrainCycles) @(negedge clk);
		if (fail_total == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
hdl/lms_pkg.sv
hdl/lms_debounce.sv
hdl/led_mode_sequencer.sv
sim/lms_checker.sv
sim/tb_led_mode_sequencer.sv
